FILE: rtl/core/vwg_pkg.sv
package vwg_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int DEG_W     = 6;
    localparam int HORIZON_W = 5;
    localparam int ENTRY_W   = SAMPLE_W + DEG_W;

    localparam logic [DEG_W-1:0]     DEG_MAX       = 6'd63;
    localparam logic [HORIZON_W-1:0] HORIZON_RESET = 5'd16;

    localparam logic KIND_EDGE   = 1'b0;
    localparam logic KIND_DEGREE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE,
        ST_DEG,
        ST_SELF,
        ST_DONE
    } vwg_state_t;

endpackage

FILE: rtl/core/vwg_ram.sv
module vwg_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 17
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/windowed_visibility_graph.sv
// channel  | dir | handshake          | payload
// s        | in  | s_tvalid/s_tready  | s_tdata sample, s_tlast final_sample
// m        | out | m_tvalid/m_tready  | m_tdata node_a/node_b/degree, m_tuser kind, m_tlast
// apb      | in  | psel/penable/pready| horizon at byte address 0
//
// a regular sample is compared with lim earlier samples, lim = min(horizon, samples held);
// the last sample of a series also flushes the degree of every held node
// the pace is set by the single window memory: one partner read per cycle while the
// pending stage has room; the registered read data is then evaluated and written back
// rst_n clears control state only; a fill count marks valid window entries
// a stalled output register freezes the walk, a result waits in one pending stage
module windowed_visibility_graph #(
    parameter int MAX_HORIZON = 16,
    parameter int INDEX_BITS  = 20
) (
    input  logic                                                    clk,
    input  logic                                                    rst_n,
    input  logic                                                    s_tvalid,
    output logic                                                    s_tready,
    input  logic [vwg_pkg::SAMPLE_W-1:0]                            s_tdata, // sample
    input  logic                                                    s_tlast,
    output logic                                                    m_tvalid,
    input  logic                                                    m_tready,
    output logic [((2*INDEX_BITS+vwg_pkg::DEG_W+7)/8)*8-1:0]        m_tdata, // node_a, node_b, degree
    output logic                                                    m_tuser, // kind
    output logic                                                    m_tlast,
    input  logic                                                    psel,
    input  logic                                                    penable,
    input  logic                                                    pwrite,
    input  logic [1:0]                                              paddr,
    input  logic [31:0]                                             pwdata,
    output logic [31:0]                                             prdata,
    output logic                                                    pready
);

    import vwg_pkg::*;

    localparam int OUT_W = ((2*INDEX_BITS + DEG_W + 7) / 8) * 8;
    localparam int DEPTH = MAX_HORIZON + 1;
    localparam int SW    = $clog2(MAX_HORIZON + 1);
    localparam int DW    = $clog2(MAX_HORIZON + 2);
    localparam int CW    = DW > HORIZON_W ? DW : HORIZON_W;
    localparam int PW    = SAMPLE_W + 1 + DW + 1;

    vwg_state_t                    st_reg, st_next;
    logic signed [SAMPLE_W-1:0]    x_reg, x_next;
    logic                          fin_reg, fin_next;
    logic [INDEX_BITS-1:0]         j_reg, j_next;
    logic [DW-1:0]                 lim_reg, lim_next;
    logic [DW-1:0]                 dist_reg, dist_next;
    logic                          ev_valid_reg, ev_valid_next;
    logic [DW-1:0]                 ev_dist_reg, ev_dist_next;
    logic [SW-1:0]                 ev_slot_reg, ev_slot_next;
    logic                          best_valid_reg, best_valid_next;
    logic signed [SAMPLE_W:0]      best_num_reg, best_num_next;
    logic [DW-1:0]                 best_den_reg, best_den_next;
    logic [DEG_W-1:0]              deg_cur_reg, deg_cur_next;
    logic                          pnd_valid_reg, pnd_valid_next;
    logic                          pnd_kind_reg, pnd_kind_next;
    logic [INDEX_BITS-1:0]         pnd_a_reg, pnd_a_next;
    logic [INDEX_BITS-1:0]         pnd_b_reg, pnd_b_next;
    logic [DEG_W-1:0]              pnd_deg_reg, pnd_deg_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_kind_reg, out_kind_next;
    logic [INDEX_BITS-1:0]         out_a_reg, out_a_next;
    logic [INDEX_BITS-1:0]         out_b_reg, out_b_next;
    logic [DEG_W-1:0]              out_deg_reg, out_deg_next;
    logic                          out_last_reg, out_last_next;
    logic [SW-1:0]                 ptr_reg, ptr_next;
    logic [DW-1:0]                 fill_reg, fill_next;
    logic [INDEX_BITS-1:0]         count_reg, count_next;
    logic [HORIZON_W-1:0]          horizon_reg, horizon_next;

    logic                          ram_we;
    logic [SW-1:0]                 ram_waddr;
    logic [ENTRY_W-1:0]            ram_wdata;
    logic [SW-1:0]                 ram_raddr;
    logic [ENTRY_W-1:0]            ram_rdata;

    logic signed [SAMPLE_W-1:0]    rd_y;
    logic [DEG_W-1:0]              rd_deg;
    logic signed [SAMPLE_W:0]      diff;
    logic signed [PW-1:0]          prod_new;
    logic signed [PW-1:0]          prod_best;
    logic                          vis;
    logic                          out_free;
    logic                          pend_free;
    logic                          out_load;
    logic                          push_last;
    logic                          new_res;
    logic                          new_kind;
    logic [INDEX_BITS-1:0]         new_a;
    logic [INDEX_BITS-1:0]         new_b;
    logic [DEG_W-1:0]              new_deg;
    logic [CW-1:0]                 hz_ext;
    logic [CW-1:0]                 h_c;
    logic [DW-1:0]                 h;
    logic [DW-1:0]                 lim_c;
    logic [SW-1:0]                 iss_slot;
    logic                          fill_full;

    function automatic logic [SW-1:0] slot_back(input logic [SW-1:0] p, input logic [DW-1:0] d);
        logic [DW:0] pe;
        logic [DW:0] de;
        pe = (DW+1)'(p);
        de = {1'b0, d};
        if (pe >= de)
        begin
            return SW'(pe - de);
        end
        return SW'(pe + (DW+1)'(DEPTH) - de);
    endfunction

    function automatic logic [DEG_W-1:0] sat_inc(input logic [DEG_W-1:0] v);
        return (v == DEG_MAX) ? v : v + DEG_W'(1);
    endfunction

    vwg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_y      = signed'(ram_rdata[SAMPLE_W-1:0]);
    assign rd_deg    = ram_rdata[ENTRY_W-1:SAMPLE_W];
    assign diff      = {rd_y[SAMPLE_W-1], rd_y} - {x_reg[SAMPLE_W-1], x_reg};
    assign prod_new  = diff * signed'({1'b0, best_den_reg});
    assign prod_best = best_num_reg * signed'({1'b0, ev_dist_reg});
    assign vis       = !best_valid_reg || (prod_new > prod_best);

    assign out_free  = !out_valid_reg || m_tready;
    assign pend_free = !pnd_valid_reg || out_free;
    assign fill_full = (fill_reg == DW'(MAX_HORIZON));
    assign iss_slot  = slot_back(ptr_reg, dist_reg);

    assign hz_ext = CW'(horizon_reg);
    assign h_c    = (hz_ext == '0) ? CW'(1) :
                    (hz_ext > CW'(MAX_HORIZON)) ? CW'(MAX_HORIZON) : hz_ext;
    assign h      = DW'(h_c);
    assign lim_c  = (h < fill_reg) ? h : fill_reg;

    always_comb
    begin
        st_next         = st_reg;
        x_next          = x_reg;
        fin_next        = fin_reg;
        j_next          = j_reg;
        lim_next        = lim_reg;
        dist_next       = dist_reg;
        ev_valid_next   = ev_valid_reg;
        ev_dist_next    = ev_dist_reg;
        ev_slot_next    = ev_slot_reg;
        best_valid_next = best_valid_reg;
        best_num_next   = best_num_reg;
        best_den_next   = best_den_reg;
        deg_cur_next    = deg_cur_reg;
        ptr_next        = ptr_reg;
        fill_next       = fill_reg;
        count_next      = count_reg;
        ram_we          = 1'b0;
        ram_waddr       = ev_slot_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = iss_slot;
        new_res         = 1'b0;
        new_kind        = KIND_EDGE;
        new_a           = j_reg - INDEX_BITS'(ev_dist_reg);
        new_b           = '0;
        new_deg         = '0;
        push_last       = 1'b0;

        case (st_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    x_next          = signed'(s_tdata);
                    fin_next        = s_tlast;
                    j_next          = count_reg;
                    lim_next        = lim_c;
                    dist_next       = DW'(1);
                    ev_valid_next   = 1'b0;
                    best_valid_next = 1'b0;
                    deg_cur_next    = '0;
                    st_next         = ST_EDGE;
                end
            end
            ST_EDGE:
            begin
                if (ev_valid_reg && vis && pend_free)
                begin
                    ram_we          = 1'b1;
                    ram_wdata       = {sat_inc(rd_deg), ram_rdata[SAMPLE_W-1:0]};
                    new_res         = 1'b1;
                    new_kind        = KIND_EDGE;
                    new_b           = j_reg;
                    deg_cur_next    = sat_inc(deg_cur_reg);
                    best_valid_next = 1'b1;
                    best_num_next   = diff;
                    best_den_next   = ev_dist_reg;
                end
                if (!ev_valid_reg || !vis || pend_free)
                begin
                    if (dist_reg <= lim_reg)
                    begin
                        ev_valid_next = 1'b1;
                        ev_dist_next  = dist_reg;
                        ev_slot_next  = iss_slot;
                        dist_next     = dist_reg + DW'(1);
                    end
                    else
                    begin
                        ev_valid_next = 1'b0;
                        dist_next     = fin_reg ? fill_reg :
                                        (fill_full ? DW'(MAX_HORIZON) : '0);
                        st_next       = ST_DEG;
                    end
                end
                else
                begin
                    ram_raddr = ev_slot_reg;
                end
            end
            ST_DEG:
            begin
                if (ev_valid_reg && pend_free)
                begin
                    new_res  = 1'b1;
                    new_kind = KIND_DEGREE;
                    new_deg  = rd_deg;
                end
                if (!ev_valid_reg || pend_free)
                begin
                    if (dist_reg != '0)
                    begin
                        ev_valid_next = 1'b1;
                        ev_dist_next  = dist_reg;
                        ev_slot_next  = iss_slot;
                        dist_next     = fin_reg ? dist_reg - DW'(1) : '0;
                    end
                    else
                    begin
                        ev_valid_next = 1'b0;
                        st_next       = fin_reg ? ST_SELF : ST_DONE;
                    end
                end
                else
                begin
                    ram_raddr = ev_slot_reg;
                end
            end
            ST_SELF:
            begin
                if (pend_free)
                begin
                    new_res  = 1'b1;
                    new_kind = KIND_DEGREE;
                    new_a    = j_reg;
                    new_deg  = deg_cur_reg;
                    st_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!pnd_valid_reg || out_free)
                begin
                    push_last = pnd_valid_reg;
                    if (fin_reg)
                    begin
                        ptr_next   = '0;
                        fill_next  = '0;
                        count_next = '0;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = ptr_reg;
                        ram_wdata  = {deg_cur_reg, x_reg};
                        ptr_next   = (ptr_reg == SW'(MAX_HORIZON)) ? '0 : ptr_reg + SW'(1);
                        fill_next  = fill_full ? fill_reg : fill_reg + DW'(1);
                        count_next = count_reg + INDEX_BITS'(1);
                    end
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // pending stage and output register
    always_comb
    begin
        out_load       = (new_res && pnd_valid_reg) || push_last;
        pnd_valid_next = pnd_valid_reg;
        pnd_kind_next  = pnd_kind_reg;
        pnd_a_next     = pnd_a_reg;
        pnd_b_next     = pnd_b_reg;
        pnd_deg_next   = pnd_deg_reg;
        if (new_res)
        begin
            pnd_valid_next = 1'b1;
            pnd_kind_next  = new_kind;
            pnd_a_next     = new_a;
            pnd_b_next     = new_b;
            pnd_deg_next   = new_deg;
        end
        else if (push_last)
        begin
            pnd_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_a_next     = out_a_reg;
        out_b_next     = out_b_reg;
        out_deg_next   = out_deg_reg;
        out_last_next  = out_last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = pnd_kind_reg;
            out_a_next     = pnd_a_reg;
            out_b_next     = pnd_b_reg;
            out_deg_next   = pnd_deg_reg;
            out_last_next  = push_last;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign horizon_next = (psel && penable && pwrite) ? pwdata[HORIZON_W-1:0] : horizon_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ST_IDLE;
            ev_valid_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
            pnd_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            ptr_reg        <= '0;
            fill_reg       <= '0;
            count_reg      <= '0;
            horizon_reg    <= HORIZON_RESET;
        end
        else
        begin
            st_reg         <= st_next;
            ev_valid_reg   <= ev_valid_next;
            best_valid_reg <= best_valid_next;
            pnd_valid_reg  <= pnd_valid_next;
            out_valid_reg  <= out_valid_next;
            ptr_reg        <= ptr_next;
            fill_reg       <= fill_next;
            count_reg      <= count_next;
            horizon_reg    <= horizon_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        fin_reg      <= fin_next;
        j_reg        <= j_next;
        lim_reg      <= lim_next;
        dist_reg     <= dist_next;
        ev_dist_reg  <= ev_dist_next;
        ev_slot_reg  <= ev_slot_next;
        best_num_reg <= best_num_next;
        best_den_reg <= best_den_next;
        deg_cur_reg  <= deg_cur_next;
        pnd_kind_reg <= pnd_kind_next;
        pnd_a_reg    <= pnd_a_next;
        pnd_b_reg    <= pnd_b_next;
        pnd_deg_reg  <= pnd_deg_next;
        out_kind_reg <= out_kind_next;
        out_a_reg    <= out_a_next;
        out_b_reg    <= out_b_next;
        out_deg_reg  <= out_deg_next;
        out_last_reg <= out_last_next;
    end

    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_W'({out_deg_reg, out_b_reg, out_a_reg});
    assign prdata   = 32'(horizon_reg);
    assign pready   = 1'b1;

`ifndef SYNTHESIS
    a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !ev_valid_reg)
        else $error("window read in flight while idle");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DW'(MAX_HORIZON))
        else $error("fill count beyond window depth");

    a_edge_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_EDGE && ev_valid_reg) |-> (ev_dist_reg != '0 && ev_dist_reg <= lim_reg))
        else $error("partner distance outside limit");

    a_first_partner: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_EDGE && ev_valid_reg && ev_dist_reg == DW'(1) && pend_free)
        |=> best_valid_reg)
        else $error("nearest partner not taken as visible");

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output word overwritten before taken");
`endif

endmodule
